/* rtl/pwm_duty_frequency_meter_core_macros.svh */
// assertion macros for the pwm duty / frequency meter
// used by pwm_duty_frequency_meter_core; expects clk and rst_n in scope
`ifndef PWM_DUTY_FREQUENCY_METER_CORE_MACROS_SVH
`define PWM_DUTY_FREQUENCY_METER_CORE_MACROS_SVH

// same-cycle implication
`define PDFM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pdfm_pkg.sv */
// shared types and constants for the pwm duty / frequency meter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pdfm_pkg;

  localparam int TS_W       = 16;
  localparam int DUTY_W     = 7;
  localparam int FREQ_W     = 24;
  localparam int TICK_W     = 24;
  localparam int QUO_W      = 24;
  localparam int STEP_W     = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int DUTY_SCALE = 100;

  localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd1000000;
  localparam logic [STEP_W-1:0] DUTY_STEPS      = 5'd7;
  localparam logic [STEP_W-1:0] FREQ_STEPS      = 5'd24;

  // in_tuser command codes
  localparam logic CMD_ARM  = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // capture sequence phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RISE1 = 2'd1,
    PH_FALL  = 2'd2,
    PH_RISE2 = 2'd3
  } phase_t;

  // result sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DUTY_GO,
    ST_DUTY_RUN,
    ST_FREQ_GO,
    ST_FREQ_RUN,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/pdfm_div.sv */
// bit-serial restoring divider, one quotient bit per clock
// depends on pdfm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdfm_div #(
  parameter int DIV_W = 17
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pdfm_pkg::div_ctl_t          ctl,
  input  wire logic [DIV_W-1:0]            rem_init,
  input  wire logic [pdfm_pkg::QUO_W-1:0]  q_init,
  input  wire logic [DIV_W-1:0]            divisor,
  output pdfm_pkg::div_stat_t              stat,
  output logic [pdfm_pkg::QUO_W-1:0]       quotient
);

  localparam int QW = pdfm_pkg::QUO_W;

  logic                        busy_r;
  logic                        done_r;
  logic [pdfm_pkg::STEP_W-1:0] cnt_r;
  logic [DIV_W-1:0]            rem_r;
  logic [DIV_W-1:0]            rem_nxt;
  logic [QW-1:0]               q_r;
  logic [DIV_W:0]              shifted;
  logic [DIV_W+1:0]            diff;
  logic                        take;

  always_comb begin
    shifted = {rem_r, q_r[QW-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    take    = ~diff[DIV_W+1];
    rem_nxt = take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse after the last step
      done_r <= busy_r & ~ctl.start & (cnt_r == pdfm_pkg::STEP_W'(1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == pdfm_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= rem_init;
      q_r   <= q_init;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[QW-2:0], take};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

`default_nettype wire

/* rtl/pwm_duty_frequency_meter_core.sv */
// pwm duty / frequency meter top level: capture sequencer, result sequencer
// depends on pdfm_pkg, pdfm_div and pwm_duty_frequency_meter_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// Measures a pwm signal from input-capture beats. A beat with in_tuser = 0
// arms a measurement; beats with in_tuser = 1 carry a captured edge
// (polarity in in_tdata[0], timestamp in in_tdata[16:1]). The block records
// a rising, a falling and a second rising edge, ignoring edges of the wrong
// polarity and edges while not armed; re-arming restarts the sequence. On
// the second rising edge it forms high and low times as differences modulo
// 2^COUNTER_WIDTH and emits one result beat: duty = high*100/period and
// frequency = tick_rate/period, both truncated, or a zero-period flag in
// out_tuser with zero data. Edge and arm beats that produce no result leave
// the sequencer idle. A completing edge keeps the block busy (in_tready low)
// until the result is registered: a multiply state, then a shared
// bit-serial divider producing one quotient bit per clock, 7 bits for duty
// and 24 bits for frequency, each run entered from its own start state and
// left on the divider's done pulse, then the output state. A zero period
// skips the divider, going from the multiply state to the output state. A
// result waiting on out_tready holds the sequencer in its output state.
// tick_rate is written through cfg_we / cfg_wdata and resets to 1000000.
module pwm_duty_frequency_meter_core #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // tdata: [0] edge_rising, [16:1] timestamp, [23:17] zero
  input  wire logic [pdfm_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: [0] cmd (0 arm, 1 edge)
  input  wire logic                               in_tuser,
  // result channel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // tdata: [6:0] duty_percent, [30:7] frequency, [31] zero
  output logic [pdfm_pkg::OUT_DATA_W-1:0]         out_tdata,
  // tuser: [0] zero_period
  output logic                                    out_tuser,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [pdfm_pkg::TICK_W-1:0]        cfg_wdata
);

`include "pwm_duty_frequency_meter_core_macros.svh"

  localparam int CW  = COUNTER_WIDTH;
  localparam int PW  = CW + 1;                 // period width
  localparam int PRW = CW + pdfm_pkg::DUTY_W;  // high*100 width
  localparam int QW  = pdfm_pkg::QUO_W;
  localparam int DW  = pdfm_pkg::DUTY_W;

  // input fields
  logic          cmd_edge;
  logic          edge_rising;
  logic [CW-1:0] ts_c;
  logic          in_acc;
  logic          complete_w;

  // capture state
  pdfm_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]    first_rise_r;
  logic [CW-1:0]    fall_r;
  logic [pdfm_pkg::TICK_W-1:0] tick_rate_r;

  // result sequencer and datapath
  pdfm_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0]  high_c;
  logic [CW-1:0]  low_c;
  logic [CW-1:0]  high_r;
  logic [PW-1:0]  period_r;
  logic [PRW-1:0] prod_r;
  logic [DW-1:0]  duty_r;
  logic [pdfm_pkg::FREQ_W-1:0] freq_r;
  logic           zero_r;
  logic           out_free;

  // output register
  logic                              out_valid_r;
  logic [pdfm_pkg::OUT_DATA_W-1:0]   out_data_r;
  logic                              out_user_r;

  // divider hookup
  pdfm_pkg::div_ctl_t  div_ctl;
  pdfm_pkg::div_stat_t div_stat;
  logic [PW-1:0]       div_rem_init;
  logic [QW-1:0]       div_q_init;
  logic [QW-1:0]       div_q;

  assign cmd_edge    = (in_tuser == pdfm_pkg::CMD_EDGE);
  assign edge_rising = in_tdata[0];
  assign ts_c        = CW'(in_tdata[pdfm_pkg::TS_W:1]);  // masks or widens
  assign in_acc      = in_tvalid & in_tready;
  assign complete_w  = in_acc & cmd_edge & edge_rising & (phase_r == pdfm_pkg::PH_RISE2);
  assign out_free    = ~out_valid_r | out_tready;

  assign high_c = fall_r - first_rise_r;
  assign low_c  = ts_c - fall_r;

  // capture phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      if (!cmd_edge) begin
        phase_nxt = pdfm_pkg::PH_RISE1;
      end else begin
        unique case (phase_r)
          pdfm_pkg::PH_IDLE:  phase_nxt = pdfm_pkg::PH_IDLE;
          pdfm_pkg::PH_RISE1: if (edge_rising) phase_nxt = pdfm_pkg::PH_FALL;
          pdfm_pkg::PH_FALL:  if (!edge_rising) phase_nxt = pdfm_pkg::PH_RISE2;
          pdfm_pkg::PH_RISE2: if (edge_rising) phase_nxt = pdfm_pkg::PH_IDLE;
          default:            phase_nxt = pdfm_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pdfm_pkg::PH_IDLE;
      first_rise_r <= '0;
      fall_r       <= '0;
      tick_rate_r  <= pdfm_pkg::TICK_RATE_RESET;
    end else begin
      phase_r <= phase_nxt;
      if (in_acc && cmd_edge && edge_rising && phase_r == pdfm_pkg::PH_RISE1) begin
        first_rise_r <= ts_c;
      end
      if (in_acc && cmd_edge && !edge_rising && phase_r == pdfm_pkg::PH_FALL) begin
        fall_r <= ts_c;
      end
      if (cfg_we) begin
        tick_rate_r <= cfg_wdata;
      end
    end
  end

  // result sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pdfm_pkg::ST_IDLE:     if (complete_w) state_nxt = pdfm_pkg::ST_MUL;
      pdfm_pkg::ST_MUL:      state_nxt = (period_r == '0) ? pdfm_pkg::ST_OUT
                                                          : pdfm_pkg::ST_DUTY_GO;
      pdfm_pkg::ST_DUTY_GO:  state_nxt = pdfm_pkg::ST_DUTY_RUN;
      pdfm_pkg::ST_DUTY_RUN: if (div_stat.done) state_nxt = pdfm_pkg::ST_FREQ_GO;
      pdfm_pkg::ST_FREQ_GO:  state_nxt = pdfm_pkg::ST_FREQ_RUN;
      pdfm_pkg::ST_FREQ_RUN: if (div_stat.done) state_nxt = pdfm_pkg::ST_OUT;
      pdfm_pkg::ST_OUT:      if (out_free) state_nxt = pdfm_pkg::ST_IDLE;
      default:               state_nxt = pdfm_pkg::ST_IDLE;
    endcase
  end

  // result sequencer outputs
  always_comb begin
    in_tready     = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.steps = pdfm_pkg::DUTY_STEPS;
    div_rem_init  = {1'b0, prod_r[PRW-1:DW]};   // high*100 >> 7 is below period
    div_q_init    = {prod_r[DW-1:0], {(QW-DW){1'b0}}};
    unique case (state_r)
      pdfm_pkg::ST_IDLE:    in_tready = 1'b1;
      pdfm_pkg::ST_DUTY_GO: div_ctl.start = 1'b1;
      pdfm_pkg::ST_FREQ_GO: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = pdfm_pkg::FREQ_STEPS;
        div_rem_init  = '0;
        div_q_init    = QW'(tick_rate_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdfm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (complete_w) begin
      high_r   <= high_c;
      period_r <= {1'b0, high_c} + {1'b0, low_c};
    end
    if (state_r == pdfm_pkg::ST_MUL) begin
      prod_r <= PRW'(high_r) * PRW'(pdfm_pkg::DUTY_SCALE);
      zero_r <= (period_r == '0);
      duty_r <= '0;
      freq_r <= '0;
    end
    if (state_r == pdfm_pkg::ST_DUTY_RUN && div_stat.done) begin
      duty_r <= div_q[DW-1:0];
    end
    if (state_r == pdfm_pkg::ST_FREQ_RUN && div_stat.done) begin
      freq_r <= div_q[pdfm_pkg::FREQ_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == pdfm_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pdfm_pkg::ST_OUT && out_free) begin
      out_data_r <= {1'b0, freq_r, duty_r};
      out_user_r <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  pdfm_div #(
    .DIV_W (PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .q_init   (div_q_init),
    .divisor  (period_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // checks
  `PDFM_ASSERT_NEXT(a_complete_blocks, complete_w, !in_tready, "completing edge did not stall input")
  `PDFM_ASSERT_SAME(a_div_busy_stall, div_stat.busy, !in_tready, "input ready while divider busy")
  `PDFM_ASSERT_SAME(a_zero_payload, out_tvalid && out_tuser, out_tdata == '0, "zero-period result carries data")
  `PDFM_ASSERT_SAME(a_duty_range, out_tvalid && !out_tuser, out_tdata[6:0] <= 7'd100, "duty above 100")

endmodule

`default_nettype wire
